// File: hdl/slkf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slkf_pkg
// Shared types, constants and match helpers for the script line keyword
// flagger: payload structs, keyword patterns, character classes.
// ----------------------------------------------------------------------------
package slkf_pkg;

  // Line counter width; the reported line number carries its low 32 bits
  localparam int LINE_COUNT_BITS = 32;
  localparam int LINE_NUM_OUT_BITS = 32;

  // Character window: eleven previous bytes plus the current byte
  localparam int WIN_DEPTH  = 11;
  localparam int VIEW_DEPTH = WIN_DEPTH + 1;
  localparam int WIN_BITS   = WIN_DEPTH * 8;
  localparam int VIEW_BITS  = VIEW_DEPTH * 8;

  // Result queue between scanner and output stage
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // Check bit positions, lowest number wins as the reported reason
  localparam int NUM_CHECKS  = 6;
  localparam int HIT_GETN    = 0;
  localparam int HIT_MOD     = 1;
  localparam int HIT_GFIND   = 2;
  localparam int HIT_UNPACK  = 3;
  localparam int HIT_ENVMOD  = 4;
  localparam int HIT_SLASH   = 5;

  // Keyword patterns; the last character sits in the lowest byte
  localparam logic [VIEW_BITS-1:0] PAT_GETN    = VIEW_BITS'("table.getn");
  localparam logic [VIEW_BITS-1:0] PAT_MOD     = VIEW_BITS'("math.mod");
  localparam logic [VIEW_BITS-1:0] PAT_GFIND   = VIEW_BITS'("string.gfind");
  localparam logic [VIEW_BITS-1:0] PAT_UNPACK  = VIEW_BITS'("unpack");
  localparam logic [VIEW_BITS-1:0] PAT_MODULE  = VIEW_BITS'("module");
  localparam logic [VIEW_BITS-1:0] PAT_SETFENV = VIEW_BITS'("setfenv");
  localparam logic [VIEW_BITS-1:0] PAT_GETFENV = VIEW_BITS'("getfenv");

  localparam int LEN_GETN    = 10;
  localparam int LEN_MOD     = 8;
  localparam int LEN_GFIND   = 12;
  localparam int LEN_UNPACK  = 6;
  localparam int LEN_MODULE  = 6;
  localparam int LEN_FENV    = 7;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef logic [LINE_COUNT_BITS-1:0] line_cnt_t;
  typedef logic [NUM_CHECKS-1:0]      hit_vec_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       line_end;
  } item_t;

  typedef struct packed {
    logic [2:0]                   reason;
    logic [LINE_NUM_OUT_BITS-1:0] line_no;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } q_wr_t;

  // True when the newest len bytes of the view equal the pattern tail
  function automatic logic tail_is(input logic [VIEW_BITS-1:0] view,
                                   input logic [VIEW_BITS-1:0] pat,
                                   input int unsigned len);
    logic ok;
    ok = 1'b1;
    for (int k = 0; k < VIEW_DEPTH; k++) begin
      if (k < len && view[8*k +: 8] != pat[8*k +: 8]) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || c == "_";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
  endfunction

  // Lowest set check index
  function automatic logic [2:0] first_hit(input hit_vec_t f);
    logic [2:0] r;
    r = '0;
    for (int i = NUM_CHECKS - 1; i >= 0; i--) begin
      if (f[i]) begin
        r = 3'(i);
      end
    end
    return r;
  endfunction

endpackage

// File: hdl/script_line_keyword_flagger_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// script_line_keyword_flagger_core
// Scans script text one byte per transfer and reports lines that hold a
// deprecated call or a slash, with the reason code and one-based line number.
//
//   Channel  Handshake     Payload
//   input    push / full   item   : ch[7:0], line_end
//   result   empty / pop   result : reason[2:0], line_no[31:0]
//
// One input transfer per cycle while full is low; the keyword comparators
// work on the window in the same cycle as the byte arrives.
// A flagged line end passes through the result queue and the output
// register before it shows on the result ports: it enters the queue at the
// transfer edge and moves into the output register once that is free.
// full rises only when the four-entry result queue is full; the output
// register and queue absorb stalls on the result side.
// rst clears the window, flags, line counter, queue and output valid flag.
// ----------------------------------------------------------------------------
module script_line_keyword_flagger_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  slkf_pkg::item_t   item,
  output logic              empty,
  input  logic              pop,
  output slkf_pkg::result_t result
);
  import slkf_pkg::*;

  q_wr_t   q_wr;
  logic    q_rd;
  logic    q_empty;
  result_t q_data;
  logic    accept;

  assign accept = push && !full;

  slkf_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .wr     (q_wr)
  );

  slkf_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .full    (full),
    .rd      (q_rd),
    .empty   (q_empty),
    .rd_data (q_data)
  );

  slkf_out u_out (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_data),
    .q_rd    (q_rd),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

// File: hdl/slkf_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slkf_scan
// Front end: shifts characters through the window, runs the fixed keyword
// comparators, keeps per-line hit flags and the line counter, and writes a
// result into the queue at each flagged line end.
// ----------------------------------------------------------------------------
module slkf_scan (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  slkf_pkg::item_t item,
  output slkf_pkg::q_wr_t wr
);
  import slkf_pkg::*;

  logic [WIN_BITS-1:0]  recent;
  hit_vec_t             flags;
  logic                 waiting;
  line_cnt_t            count;

  logic [VIEW_BITS-1:0] view;
  hit_vec_t             hits;
  logic                 waiting_next;
  line_cnt_t            count_next;

  // Compare the window against every pattern
  always_comb begin
    view = {recent, item.ch};
    hits = '0;
    hits[HIT_GETN]   = tail_is(view, PAT_GETN, LEN_GETN);
    hits[HIT_MOD]    = tail_is(view, PAT_MOD, LEN_MOD);
    hits[HIT_GFIND]  = tail_is(view, PAT_GFIND, LEN_GFIND);
    hits[HIT_UNPACK] = waiting && item.ch == CH_LPAREN;
    hits[HIT_ENVMOD] = tail_is(view, PAT_MODULE, LEN_MODULE) ||
                       tail_is(view, PAT_SETFENV, LEN_FENV) ||
                       tail_is(view, PAT_GETFENV, LEN_FENV);
    hits[HIT_SLASH]  = item.ch == CH_SLASH;
    // Arm on a word-boundary "unpack", keep armed only across whitespace
    waiting_next = (waiting && is_space(item.ch)) ||
                   (tail_is(view, PAT_UNPACK, LEN_UNPACK) &&
                    !is_word(view[8*LEN_UNPACK +: 8]));
    count_next = count + 1'b1;
  end

  // Emit a result at a line end with any hit
  always_comb begin
    wr.valid        = accept && item.line_end && (flags != '0);
    wr.data.reason  = first_hit(flags);
    wr.data.line_no = LINE_NUM_OUT_BITS'(count_next);
  end

  // Advance line state
  always_ff @(posedge clk) begin
    if (rst) begin
      recent  <= '0;
      flags   <= '0;
      waiting <= 1'b0;
      count   <= '0;
    end else if (accept) begin
      if (item.line_end) begin
        recent  <= '0;
        flags   <= '0;
        waiting <= 1'b0;
        count   <= count_next;
      end else begin
        recent  <= view[WIN_BITS-1:0];
        flags   <= flags | hits;
        waiting <= waiting_next;
      end
    end
  end

`ifndef ASSERT_OFF
  a_line_clears: assert property (@(posedge clk) disable iff (rst)
    accept && item.line_end |=> flags == '0 && !waiting && recent == '0)
    else $error("line state not cleared at line end");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    accept && item.line_end |=> count == $past(count) + 1'b1)
    else $error("line counter did not advance at line end");
`endif

endmodule

// File: hdl/slkf_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slkf_fifo
// Short result queue between the scanner and the output stage.
// ----------------------------------------------------------------------------
module slkf_fifo (
  input  logic              clk,
  input  logic              rst,
  input  slkf_pkg::q_wr_t   wr,
  output logic              full,
  input  logic              rd,
  output logic              empty,
  output slkf_pkg::result_t rd_data
);
  import slkf_pkg::*;

  result_t              slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wptr;
  logic [FIFO_AW-1:0]   rptr;
  logic [FIFO_CW-1:0]   count;
  logic                 do_wr;
  logic                 do_rd;

  assign full    = count == FIFO_CW'(FIFO_DEPTH);
  assign empty   = count == '0;
  assign do_wr   = wr.valid && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = slots[rptr];

  // Store incoming results
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wr.data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(wr.valid && full))
    else $error("result written into a full queue");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == FIFO_CW'(FIFO_DEPTH)) |-> wptr == rptr)
    else $error("queue pointers disagree with fill count");
`endif

endmodule

// File: hdl/slkf_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slkf_out
// Back end: output register that presents the oldest result and refills
// from the queue in the cycle it is taken.
// ----------------------------------------------------------------------------
module slkf_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  slkf_pkg::result_t q_data,
  output logic              q_rd,
  output logic              empty,
  input  logic              pop,
  output slkf_pkg::result_t result
);
  import slkf_pkg::*;

  logic valid;

  // Refill when the register is free or being taken
  assign q_rd  = !q_empty && (!valid || pop);
  assign empty = !valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (q_rd) begin
      valid <= 1'b1;
    end else if (pop) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      result <= q_data;
    end
  end

`ifndef ASSERT_OFF
  a_refill: assert property (@(posedge clk) disable iff (rst)
    !q_empty && !valid |=> valid)
    else $error("output register not refilled from waiting queue");
`endif

endmodule
